### src/assert_macros.svh
// Assertion macros shared by the step response metrics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/srm_pkg.sv
// Shared types and constants for the step response metrics block.
package srm_pkg;

  localparam int unsigned DEFAULT_MAX_RUN_LENGTH = 65536;

  localparam int LEVEL_W    = 23;
  localparam int SCALE_W    = 24;
  localparam int SAMPLE_W   = 24;
  localparam int COUNT_W    = 17;
  localparam int PCT_W      = 32;
  localparam int ERR_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [LEVEL_W-1:0] TARGET_RESET    = 23'd65536;
  localparam logic [LEVEL_W-1:0] RISE_LOW_RESET  = 23'd6554;
  localparam logic [LEVEL_W-1:0] RISE_HIGH_RESET = 23'd58982;
  localparam logic [LEVEL_W-1:0] BAND_RESET      = 23'd3277;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd6553600;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET    = 3'd0,
    CFG_RISE_LOW  = 3'd1,
    CFG_RISE_HIGH = 3'd2,
    CFG_BAND      = 3'd3,
    CFG_SCALE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] rise_samples;
    logic [COUNT_W-1:0] settling_samples;
    logic [COUNT_W-1:0] peak_index;
    logic [PCT_W-1:0]   overshoot_percent;
    logic [ERR_W-1:0]   final_error;
    logic [COUNT_W-1:0] sample_count;
  } result_t;

endpackage

### src/step_response_metrics.sv
// Top level of the step response metrics block.
// Takes one signed Q7.16 sample per cycle and reports, at the end of each run,
// rise time, settling time and peak index in samples, overshoot percent in
// Q16.16, steady-state error and the run length. A run ends on a sample with
// last set, or on the sample at index MAX_RUN_LENGTH - 1. Throughput is one
// sample per clock: the run trackers update directly from the input
// register. The closing figures of a run are held in the finish stage, and
// the overshoot multiply result is then registered at the output. Samples keep
// flowing while a result waits at the output; input stalls only when a run
// closes with both the multiply stage and the output register occupied.
// The user writes configuration through the cfg port while idle; the block does not enforce it.
`include "assert_macros.svh"

module step_response_metrics #(
  parameter int unsigned MAX_RUN_LENGTH = srm_pkg::DEFAULT_MAX_RUN_LENGTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  srm_pkg::sample_t                sample_item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output srm_pkg::result_t                result_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_RUN_LENGTH + 1);

  // Configuration registers
  logic [srm_pkg::LEVEL_W-1:0] target_level;
  logic [srm_pkg::LEVEL_W-1:0] rise_low_level;
  logic [srm_pkg::LEVEL_W-1:0] rise_high_level;
  logic [srm_pkg::LEVEL_W-1:0] settle_band;
  logic [srm_pkg::SCALE_W-1:0] overshoot_scale;

  // Input register
  logic                                cur_valid;
  logic signed [srm_pkg::SAMPLE_W-1:0] cur_sample;
  logic                                cur_last;

  // Run trackers
  logic [CNT_W-1:0]                    sample_index;
  logic [CNT_W-1:0]                    rise_start_index;
  logic                                rise_start_seen;
  logic [CNT_W-1:0]                    rise_end_index;
  logic                                rise_end_seen;
  logic [CNT_W-1:0]                    out_of_band_index;
  logic                                out_of_band_seen;
  logic signed [srm_pkg::SAMPLE_W-1:0] peak_value;
  logic [CNT_W-1:0]                    peak_at;
  logic                                peak_seen;

  // Finish stage register
  logic                                fin_valid;
  logic [CNT_W-1:0]                    fin_rise;
  logic [CNT_W-1:0]                    fin_settle;
  logic [CNT_W-1:0]                    fin_peak_idx;
  logic [CNT_W-1:0]                    fin_count;
  logic [srm_pkg::ERR_W-1:0]           fin_err;
  logic [srm_pkg::LEVEL_W-1:0]         fin_excess;

  // Combinational tracker logic
  logic                       res_free;
  logic                       fin_free;
  logic                       cur_close;
  logic                       cur_consume;
  logic [CNT_W-1:0]           run_len;
  logic signed [24:0]         y_ext;
  logic signed [24:0]         tgt_s;
  logic signed [24:0]         low_s;
  logic signed [24:0]         high_s;
  logic signed [24:0]         diff;
  logic [24:0]                dev_mag;
  logic                       start_hit;
  logic                       end_hit;
  logic                       peak_hit;
  logic                       oob_hit;
  logic [CNT_W-1:0]           rs_idx_eff;
  logic [CNT_W-1:0]           re_idx_eff;
  logic                       rs_seen_eff;
  logic                       re_seen_eff;
  logic signed [srm_pkg::SAMPLE_W-1:0] peak_eff;
  logic signed [24:0]         excess_full;
  logic [CNT_W-1:0]           rise_val;
  logic [CNT_W-1:0]           settle_val;
  logic [CNT_W-1:0]           peak_idx_val;
  logic [srm_pkg::LEVEL_W-1:0] excess_val;
  logic [46:0]                product;
  logic [47:0]                rounded;
  srm_pkg::result_t           result_next;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level    <= srm_pkg::TARGET_RESET;
      rise_low_level  <= srm_pkg::RISE_LOW_RESET;
      rise_high_level <= srm_pkg::RISE_HIGH_RESET;
      settle_band     <= srm_pkg::BAND_RESET;
      overshoot_scale <= srm_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        srm_pkg::CFG_TARGET:    target_level    <= cfg_data[srm_pkg::LEVEL_W-1:0];
        srm_pkg::CFG_RISE_LOW:  rise_low_level  <= cfg_data[srm_pkg::LEVEL_W-1:0];
        srm_pkg::CFG_RISE_HIGH: rise_high_level <= cfg_data[srm_pkg::LEVEL_W-1:0];
        srm_pkg::CFG_BAND:      settle_band     <= cfg_data[srm_pkg::LEVEL_W-1:0];
        srm_pkg::CFG_SCALE:     overshoot_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: each stage advances when the one after it has room; only a run-closing sample needs the finish stage
  assign res_free     = !result_valid || result_ready;
  assign fin_free     = !fin_valid || res_free;
  assign cur_close    = cur_last || (sample_index == CNT_W'(MAX_RUN_LENGTH - 1));
  assign cur_consume  = cur_valid && (!cur_close || fin_free);
  assign sample_ready = !cur_valid || cur_consume;

  // Capture the incoming sample transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (sample_ready) begin
      cur_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready) begin
      cur_sample <= sample_item.sample;
      cur_last   <= sample_item.last;
    end
  end

  // Compare the current sample against the levels and the running peak
  always_comb begin
    run_len     = sample_index + CNT_W'(1);
    y_ext       = {cur_sample[srm_pkg::SAMPLE_W-1], cur_sample};
    tgt_s       = {2'b00, target_level};
    low_s       = {2'b00, rise_low_level};
    high_s      = {2'b00, rise_high_level};
    diff        = y_ext - tgt_s;
    dev_mag     = diff[24] ? 25'(-diff) : 25'(diff);
    start_hit   = !rise_start_seen && (y_ext >= low_s);
    end_hit     = !rise_end_seen && (y_ext >= high_s);
    peak_hit    = cur_sample > peak_value;
    oob_hit     = dev_mag[srm_pkg::ERR_W-1:0] > srm_pkg::ERR_W'(settle_band);

    rs_idx_eff  = start_hit ? sample_index : rise_start_index;
    re_idx_eff  = end_hit ? sample_index : rise_end_index;
    rs_seen_eff = rise_start_seen || start_hit;
    re_seen_eff = rise_end_seen || end_hit;
    peak_eff    = peak_hit ? cur_sample : peak_value;

    // Rise time falls back to the run length without a proper crossing
    if (rs_seen_eff && re_seen_eff && (re_idx_eff > rs_idx_eff)) begin
      rise_val = re_idx_eff - rs_idx_eff;
    end else begin
      rise_val = run_len;
    end

    // An out-of-band current sample settles at the run length too
    if (oob_hit || !out_of_band_seen) begin
      settle_val = run_len;
    end else begin
      settle_val = out_of_band_index + CNT_W'(1);
    end

    if (peak_hit) begin
      peak_idx_val = sample_index;
    end else if (peak_seen) begin
      peak_idx_val = peak_at;
    end else begin
      peak_idx_val = run_len;
    end

    // Peak never exceeds the 23-bit positive range, so the excess fits
    excess_full = {peak_eff[srm_pkg::SAMPLE_W-1], peak_eff} - tgt_s;
    excess_val  = (excess_full > 25'sd0) ? excess_full[srm_pkg::LEVEL_W-1:0] : '0;
  end

  // Update the run trackers; clear them when the run closes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index      <= '0;
      rise_start_index  <= '0;
      rise_start_seen   <= 1'b0;
      rise_end_index    <= '0;
      rise_end_seen     <= 1'b0;
      out_of_band_index <= '0;
      out_of_band_seen  <= 1'b0;
      peak_value        <= '0;
      peak_at           <= '0;
      peak_seen         <= 1'b0;
    end else if (cur_consume) begin
      if (cur_close) begin
        sample_index      <= '0;
        rise_start_index  <= '0;
        rise_start_seen   <= 1'b0;
        rise_end_index    <= '0;
        rise_end_seen     <= 1'b0;
        out_of_band_index <= '0;
        out_of_band_seen  <= 1'b0;
        peak_value        <= '0;
        peak_at           <= '0;
        peak_seen         <= 1'b0;
      end else begin
        sample_index     <= run_len;
        rise_start_index <= rs_idx_eff;
        rise_start_seen  <= rs_seen_eff;
        rise_end_index   <= re_idx_eff;
        rise_end_seen    <= re_seen_eff;
        if (oob_hit) begin
          out_of_band_index <= sample_index;
          out_of_band_seen  <= 1'b1;
        end
        if (peak_hit) begin
          peak_value <= cur_sample;
          peak_at    <= sample_index;
          peak_seen  <= 1'b1;
        end
      end
    end
  end

  // Hold the closing figures for the overshoot multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (cur_consume && cur_close) begin
      fin_valid <= 1'b1;
    end else if (res_free) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_consume && cur_close) begin
      fin_rise     <= rise_val;
      fin_settle   <= settle_val;
      fin_peak_idx <= peak_idx_val;
      fin_count    <= run_len;
      fin_err      <= dev_mag[srm_pkg::ERR_W-1:0];
      fin_excess   <= excess_val;
    end
  end

  // Scale the excess to percent with rounding; the product stays below 2^47,
  // so the rounded result always fits 32 bits
  always_comb begin
    product = 47'(fin_excess) * 47'(overshoot_scale);
    rounded = 48'(product) + 48'h8000;
    result_next.rise_samples      = srm_pkg::COUNT_W'(fin_rise);
    result_next.settling_samples  = srm_pkg::COUNT_W'(fin_settle);
    result_next.peak_index        = srm_pkg::COUNT_W'(fin_peak_idx);
    result_next.overshoot_percent = rounded[47:16];
    result_next.final_error       = fin_err;
    result_next.sample_count      = srm_pkg::COUNT_W'(fin_count);
  end

  // Present the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_free) begin
      result_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && fin_valid) begin
      result_item <= result_next;
    end
  end

  `ASSERT_ALWAYS(a_index_range, sample_index < CNT_W'(MAX_RUN_LENGTH), "sample index past run limit")
  `ASSERT_NEXT(a_clear_after_run, cur_consume && cur_close, sample_index == '0 && !peak_seen && !rise_start_seen && !rise_end_seen && !out_of_band_seen, "run state not cleared")
  `ASSERT_IMPLIES(a_peak_positive, peak_seen, peak_value > 24'sd0, "tracked peak not positive")
  `ASSERT_IMPLIES(a_fin_bounds, fin_valid, fin_rise <= fin_count && fin_settle <= fin_count && fin_peak_idx <= fin_count, "finish figures exceed run length")

endmodule
